/* sv/bpm_clock_divider_top_defines.svh */
// ----------------------------------------------------------------------------
// bpm clock divider assertion macros
// shared concurrent assertion forms for the tempo clock generator
// ----------------------------------------------------------------------------
`ifndef BPM_CLOCK_DIVIDER_TOP_DEFINES_SVH
`define BPM_CLOCK_DIVIDER_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define BCD_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// invariant checked on every clock edge, reset included
`define BCD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/bcd_pkg.sv */
// ----------------------------------------------------------------------------
// bcd_pkg
// types and constants of the tempo clock generator
// ----------------------------------------------------------------------------
package bcd_pkg;

   localparam int unsigned TEMPO_W   = 9;
   localparam int unsigned STEP_W    = 5;
   localparam int unsigned DIVTAB_W  = 48;
   localparam int unsigned DIVISOR_W = 6;
   localparam int unsigned ELAPSED_W = 15;
   localparam int unsigned TURN_W    = 2;
   localparam int unsigned GATES_W   = 8;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned MAX_OUTPUTS = 8;

   localparam logic [ELAPSED_W-1:0] HALF_MINUTE_MS = 15'd30000;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = 15'd32767;

   localparam logic [TEMPO_W-1:0]  MAX_BPM_RST     = 9'd300;
   localparam logic [STEP_W-1:0]   COARSE_STEP_RST = 5'd5;
   localparam logic [STEP_W-1:0]   FINE_STEP_RST   = 5'd1;
   localparam logic [DIVTAB_W-1:0] DIVTAB_RST      = 48'd141845691908290;
   localparam logic [TEMPO_W-1:0]  BPM_RST         = 9'd120;

   typedef enum logic [TURN_W-1:0] {
      TURN_NONE = 2'd0,
      TURN_UP   = 2'd1,
      TURN_DOWN = 2'd2,
      TURN_RSVD = 2'd3
   } turn_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_BPM     = 2'd0,
      CSR_COARSE_STEP = 2'd1,
      CSR_FINE_STEP   = 2'd2,
      CSR_DIVTAB      = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

/* sv/bcd_if.sv */
// ----------------------------------------------------------------------------
// bcd channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface bcd_req_if import bcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              ms_tick;
   logic [TURN_W-1:0] turn;
   logic              button_press;

   modport source (output valid, output ms_tick, output turn, output button_press,
                   input ready);
   modport sink (input valid, input ms_tick, input turn, input button_press,
                 output ready);
endinterface

interface bcd_rsp_if import bcd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [GATES_W-1:0] gates;
   logic [TEMPO_W-1:0] tempo;
   logic               fine_mode;
   logic               beat;

   modport source (output valid, output gates, output tempo, output fine_mode,
                   output beat, input ready);
   modport sink (input valid, input gates, input tempo, input fine_mode,
                 input beat, output ready);
endinterface

interface bcd_csr_if import bcd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIVTAB_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/bpm_clock_divider_top.sv */
// ----------------------------------------------------------------------------
// bpm_clock_divider_top
// tempo clock generator with divided gate outputs
// ----------------------------------------------------------------------------
// One request is one control loop pass: a millisecond tick, an encoder turn and
// a button press. Each request is accepted in the idle state; a bit-serial
// restoring divider then forms the half-period floor(30000 / tempo) one quotient
// bit per cycle, and the done state updates the elapsed counter, the phase
// counters and the tempo. A response waiting in the output register holds the
// update until it is taken. Register writes are accepted in every cycle.
`include "bpm_clock_divider_top_defines.svh"

module bpm_clock_divider_top import bcd_pkg::*; #(
   parameter int unsigned NUM_OUTPUTS = 8
) (
   input  logic       clock,
   input  logic       reset,
   bcd_req_if.sink    req_ch,
   bcd_rsp_if.source  rsp_ch,
   bcd_csr_if.sink    csr_ch
);

   localparam int unsigned DIV_STEPS = ELAPSED_W;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

   // configuration registers
   logic [TEMPO_W-1:0]  max_bpm_ff;
   logic [STEP_W-1:0]   coarse_step_ff;
   logic [STEP_W-1:0]   fine_step_ff;
   logic [DIVTAB_W-1:0] divtab_ff;

   // control state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_ready;
   logic                commit;

   // loop state
   logic [TEMPO_W-1:0]   bpm_ff, bpm_in;
   logic                 fine_sel_ff, fine_sel_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic                 started_ff, started_in;
   logic [DIVISOR_W-1:0] phase_ff [NUM_OUTPUTS];
   logic [DIVISOR_W-1:0] phase_in [NUM_OUTPUTS];

   // latched request
   logic                 tick_ff;
   logic [TURN_W-1:0]    turn_ff;
   logic                 press_ff;

   // divider
   logic [TEMPO_W-1:0]   rem_ff, rem_in;
   logic [ELAPSED_W-1:0] quo_ff, quo_in;
   logic [TEMPO_W:0]     rem_shift;
   logic                 rem_ge;

   // response payload
   logic [GATES_W-1:0]   gates_ff, gates_in;
   logic                 beat_ff, beat_in;

   // update datapath
   logic [ELAPSED_W-1:0] el_tick;
   logic                 do_beat;
   logic [STEP_W-1:0]    step;
   logic [TEMPO_W:0]     bpm_up;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bpm_ff     <= MAX_BPM_RST;
         coarse_step_ff <= COARSE_STEP_RST;
         fine_step_ff   <= FINE_STEP_RST;
         divtab_ff      <= DIVTAB_RST;
      end else if (csr_ch.valid) begin
         case (csr_idx_type'(csr_ch.index))
            CSR_MAX_BPM:     max_bpm_ff     <= csr_ch.data[TEMPO_W-1:0];
            CSR_COARSE_STEP: coarse_step_ff <= csr_ch.data[STEP_W-1:0];
            CSR_FINE_STEP:   fine_step_ff   <= csr_ch.data[STEP_W-1:0];
            CSR_DIVTAB:      divtab_ff      <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_ch.valid) state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == '0) state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff || rsp_ch.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DIV:  ;
         ST_DONE: commit = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   assign req_ch.ready = req_ready;

   // bit-serial restoring divider
   assign rem_shift = {rem_ff, quo_ff[ELAPSED_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, bpm_ff};

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (req_ready && req_ch.valid) begin
         cnt_in = CNT_W'(DIV_STEPS - 1);
         rem_in = '0;
         quo_in = HALF_MINUTE_MS;
      end else if (state_ff == ST_DIV) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = rem_ge ? TEMPO_W'(rem_shift - {1'b0, bpm_ff}) : rem_shift[TEMPO_W-1:0];
         quo_in = {quo_ff[ELAPSED_W-2:0], rem_ge};
      end
   end

   // loop update
   assign el_tick = (tick_ff && elapsed_ff != ELAPSED_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign do_beat = (bpm_ff != '0) && (el_tick >= quo_ff);
   assign step    = fine_sel_ff ? fine_step_ff : coarse_step_ff;
   assign bpm_up  = {1'b0, bpm_ff} + {{(TEMPO_W + 1 - STEP_W){1'b0}}, step};

   always_comb begin
      logic [DIVISOR_W-1:0] div;
      logic [DIVISOR_W:0]   p1;
      div         = '0;
      p1          = '0;
      elapsed_in  = elapsed_ff;
      started_in  = started_ff;
      bpm_in      = bpm_ff;
      fine_sel_in = fine_sel_ff;
      beat_in     = beat_ff;
      gates_in    = gates_ff;
      phase_in    = phase_ff;
      if (commit) begin
         elapsed_in = do_beat ? '0 : el_tick;
         started_in = started_ff | do_beat;
         beat_in    = do_beat;
         for (int i = 0; i < NUM_OUTPUTS; i++) begin
            div = divtab_ff[i*DIVISOR_W +: DIVISOR_W];
            p1  = {1'b0, phase_ff[i]} + 1'b1;
            if (do_beat && started_ff) begin
               if (div <= DIVISOR_W'(1) || p1 >= {1'b0, div}) begin
                  phase_in[i] = '0;
               end else begin
                  phase_in[i] = p1[DIVISOR_W-1:0];
               end
            end
         end
         case (turn_type'(turn_ff))
            TURN_UP:   bpm_in = (bpm_up > {1'b0, max_bpm_ff}) ? max_bpm_ff
                                                                : bpm_up[TEMPO_W-1:0];
            TURN_DOWN: bpm_in = (bpm_ff < {{(TEMPO_W - STEP_W){1'b0}}, step}) ? '0
                               : bpm_ff - {{(TEMPO_W - STEP_W){1'b0}}, step};
            default:   ;
         endcase
         fine_sel_in = fine_sel_ff ^ press_ff;
         gates_in = '0;
         for (int i = 0; i < NUM_OUTPUTS; i++) begin
            gates_in[i] = (started_ff | do_beat) && (phase_in[i] == '0);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bpm_ff       <= BPM_RST;
         fine_sel_ff  <= 1'b0;
         elapsed_ff   <= '0;
         started_ff   <= 1'b0;
         for (int i = 0; i < NUM_OUTPUTS; i++) begin
            phase_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bpm_ff       <= bpm_in;
         fine_sel_ff  <= fine_sel_in;
         elapsed_ff   <= elapsed_in;
         started_ff   <= started_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      gates_ff <= gates_in;
      beat_ff  <= beat_in;
      if (req_ready && req_ch.valid) begin
         tick_ff  <= req_ch.ms_tick;
         turn_ff  <= req_ch.turn;
         press_ff <= req_ch.button_press;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.gates     = gates_ff;
   assign rsp_ch.tempo     = bpm_ff;
   assign rsp_ch.fine_mode = fine_sel_ff;
   assign rsp_ch.beat      = beat_ff;

   `BCD_ASSERT_IMPL(a_accept_starts_div, clock, reset, (req_ch.valid && req_ch.ready) |=> (state_ff == ST_DIV), "accepted request did not start the divider")
   `BCD_ASSERT_IMPL(a_div_ends, clock, reset, (state_ff == ST_DIV && cnt_ff == '0) |=> (state_ff == ST_DONE), "divider overran its bit count")
   `BCD_ASSERT_IMPL(a_beat_started, clock, reset, (rsp_ch.valid && rsp_ch.beat) |-> started_ff, "beat reported before start")
   `BCD_ASSERT_ALWAYS(a_rsp_state, clock, rsp_ch.valid |-> (rsp_ch.tempo == bpm_ff && rsp_ch.fine_mode == fine_sel_ff), "response out of step with loop state")

endmodule
